// ===== hw/rtl/multi_queue_linked_list_manager_core_assert.svh =====
// Assertion macros used by the queue manager's port-level checker.
`ifndef MULTI_QUEUE_LINKED_LIST_MANAGER_CORE_ASSERT_SVH
`define MULTI_QUEUE_LINKED_LIST_MANAGER_CORE_ASSERT_SVH

// Concurrent assertion on a given clock with an active-low reset
`define MQLL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("queue manager assertion failed");

// Same, on the block's own clock and reset
`define MQLL_ASSERT_CLK(lbl, prop) `MQLL_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

// ===== hw/rtl/mqll_pkg.sv =====
// Package: sizes, command and status codes, sequencer types of the queue manager.
`timescale 1ns / 1ps
package mqll_pkg;

    localparam int NUM_QUEUES = 128;
    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int SEL_W      = 7;
    localparam int VAL_W      = 32;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MERGE   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDQ,
        S_RDT,
        S_EXE
    } t_state;

    typedef struct packed {
        logic ready;
        logic rd_q;
        logic rd_t;
        logic exe;
    } t_seq_ctl;

endpackage

// ===== hw/rtl/mqll_if.sv =====
// Request and response channel interfaces of the queue manager.
`timescale 1ns / 1ps
interface mqll_cmd_if import mqll_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [SEL_W-1:0]         queue_sel;
    logic [SEL_W-1:0]         other_queue;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, mode, queue_sel, other_queue, value, input ready);
    modport sink   (input valid, mode, queue_sel, other_queue, value, output ready);
endinterface

interface mqll_rsp_if import mqll_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [VAL_W-1:0]  data_out;
    logic                     now_empty;

    modport source (output valid, status, data_out, now_empty, input ready);
    modport sink   (input valid, status, data_out, now_empty, output ready);
endinterface

// ===== hw/rtl/multi_queue_linked_list_manager_core.sv =====
// Flow: S_RDQ and S_RDT make two dependent reads of the single-read-port head, tail
// and node memories; the commit in S_EXE waits for a free response slot.
// A new request is taken only in S_IDLE, after the commit of the one before.
// Reset (synchronous, active low) clears queue valid bits, free stack and fresh count;
// pointer and node memories need no clearing pass, so requests are taken right away.
`timescale 1ns / 1ps
module multi_queue_linked_list_manager_core import mqll_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mqll_cmd_if.sink   i_cmd,
    mqll_rsp_if.source o_rsp
);

    t_seq_ctl ctl;
    logic     accept;
    logic     out_free;
    logic     commit;

    // Latched request
    logic [MODE_W-1:0]       r_mode;
    logic [SEL_W-1:0]        r_qs;
    logic [SEL_W-1:0]        r_qt;
    logic signed [VAL_W-1:0] r_value;

    // Pool and queue control state
    logic [NUM_QUEUES-1:0] r_head_vld, n_head_vld;
    logic [NODE_W-1:0]     r_free_top, n_free_top;
    logic                  r_free_vld, n_free_vld;
    logic [CNT_W-1:0]      r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]      r_fresh_cnt, n_fresh_cnt;

    // Pointers gathered by the read steps
    logic [NODE_W-1:0] r_hq;
    logic [NODE_W-1:0] r_tq;
    logic [NODE_W-1:0] r_link_free;

    // Response register
    logic                    r_out_vld;
    logic [STAT_W-1:0]       r_status, n_status;
    logic signed [VAL_W-1:0] r_data, n_data;
    logic                    r_empty, n_empty;

    // Memory ports
    logic              head_we, tail_we, link_we, data_we;
    logic [SEL_W-1:0]  head_waddr, tail_waddr, q_raddr;
    logic [NODE_W-1:0] head_wdata, tail_wdata, head_rdata, tail_rdata;
    logic [NODE_W-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
    logic [NODE_W-1:0] data_waddr, node_raddr;
    logic [VAL_W-1:0]  data_rdata;

    // Allocation and range decode
    logic              use_free, use_fresh, qs_rng, qt_rng, qs_e, qt_e;
    logic [NODE_W-1:0] alloc;

    assign accept      = i_cmd.valid && ctl.ready;
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign commit      = ctl.exe && out_free;
    assign i_cmd.ready = ctl.ready;

    mqll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    // Read addresses: source queue first, then target queue and the head node
    // hold the head node address while the commit step waits
    assign q_raddr    = ctl.rd_q ? r_qs : r_qt;
    assign node_raddr = ctl.rd_t ? head_rdata : r_hq;
    assign link_raddr = ctl.rd_q ? r_free_top : node_raddr;

    mqll_ram #(.WIDTH(NODE_W), .DEPTH(NUM_QUEUES), .ADDR_W(SEL_W)) u_head_ram (
        .i_clk (i_clk), .i_we (head_we), .i_waddr (head_waddr), .i_wdata (head_wdata),
        .i_raddr (q_raddr), .o_rdata (head_rdata)
    );

    mqll_ram #(.WIDTH(NODE_W), .DEPTH(NUM_QUEUES), .ADDR_W(SEL_W)) u_tail_ram (
        .i_clk (i_clk), .i_we (tail_we), .i_waddr (tail_waddr), .i_wdata (tail_wdata),
        .i_raddr (q_raddr), .o_rdata (tail_rdata)
    );

    mqll_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT), .ADDR_W(NODE_W)) u_link_ram (
        .i_clk (i_clk), .i_we (link_we), .i_waddr (link_waddr), .i_wdata (link_wdata),
        .i_raddr (link_raddr), .o_rdata (link_rdata)
    );

    mqll_ram #(.WIDTH(VAL_W), .DEPTH(NODE_COUNT), .ADDR_W(NODE_W)) u_data_ram (
        .i_clk (i_clk), .i_we (data_we), .i_waddr (data_waddr), .i_wdata (r_value),
        .i_raddr (node_raddr), .o_rdata (data_rdata)
    );

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_cmd.mode;
            r_qs    <= i_cmd.queue_sel;
            r_qt    <= i_cmd.other_queue;
            r_value <= i_cmd.value;
        end
    end

    // Hold source pointers and the free-stack link from the first read step
    always_ff @(posedge i_clk) begin
        if (ctl.rd_t) begin
            r_hq        <= head_rdata;
            r_tq        <= tail_rdata;
            r_link_free <= link_rdata;
        end
    end

    assign qs_rng    = int'(r_qs) < NUM_QUEUES;
    assign qt_rng    = int'(r_qt) < NUM_QUEUES;
    assign qs_e      = !r_head_vld[r_qs];
    assign qt_e      = !r_head_vld[r_qt];
    assign use_free  = r_free_vld && (r_free_cnt != '0);
    assign use_fresh = !use_free && (r_fresh_cnt < CNT_W'(NODE_COUNT));
    assign alloc     = use_free ? r_free_top : r_fresh_cnt[NODE_W-1:0];

    // Commit step: memory writes, pool update and the response
    always_comb begin
        head_we     = 1'b0;
        head_waddr  = r_qs;
        head_wdata  = alloc;
        tail_we     = 1'b0;
        tail_waddr  = r_qs;
        tail_wdata  = alloc;
        link_we     = 1'b0;
        link_waddr  = r_tq;
        link_wdata  = alloc;
        data_we     = 1'b0;
        data_waddr  = alloc;
        n_head_vld  = r_head_vld;
        n_free_top  = r_free_top;
        n_free_vld  = r_free_vld;
        n_free_cnt  = r_free_cnt;
        n_fresh_cnt = r_fresh_cnt;
        n_status    = STAT_OK;
        n_data      = '0;
        n_empty     = 1'b1;
        if (qs_rng) begin
            case (r_mode)
                MODE_APPEND: begin
                    if (use_free || use_fresh) begin
                        data_we = 1'b1;
                        tail_we = 1'b1;
                        if (qs_e) begin
                            head_we           = 1'b1;
                            n_head_vld[r_qs]  = 1'b1;
                        end else begin
                            link_we = 1'b1;
                        end
                        // pop the free stack or hand out a fresh node
                        if (use_free) begin
                            n_free_cnt = r_free_cnt - 1'b1;
                            n_free_vld = (r_free_cnt != CNT_W'(1));
                            n_free_top = r_link_free;
                        end else begin
                            n_fresh_cnt = r_fresh_cnt + 1'b1;
                        end
                        n_empty = 1'b0;
                    end else begin
                        n_status = STAT_FULL;
                        n_empty  = qs_e;
                    end
                end
                MODE_DEQUEUE: begin
                    if (qs_e) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_data = data_rdata;
                        if (r_hq == r_tq) begin
                            n_head_vld[r_qs] = 1'b0;
                        end else begin
                            head_we    = 1'b1;
                            head_wdata = link_rdata;
                            n_empty    = 1'b0;
                        end
                        // push the freed head node
                        link_we    = 1'b1;
                        link_waddr = r_hq;
                        link_wdata = r_free_vld ? r_free_top : '0;
                        n_free_top = r_hq;
                        n_free_vld = 1'b1;
                        n_free_cnt = r_free_cnt + 1'b1;
                    end
                end
                MODE_MERGE: begin
                    if (qt_rng && (r_qt != r_qs) && !qs_e) begin
                        if (qt_e) begin
                            head_we          = 1'b1;
                            head_waddr       = r_qt;
                            head_wdata       = r_hq;
                            n_head_vld[r_qt] = 1'b1;
                        end else begin
                            link_we    = 1'b1;
                            link_waddr = tail_rdata;
                            link_wdata = r_hq;
                        end
                        tail_we          = 1'b1;
                        tail_waddr       = r_qt;
                        tail_wdata       = r_tq;
                        n_head_vld[r_qs] = 1'b0;
                    end
                    n_empty = ((r_qt != r_qs) || !qt_rng) ? 1'b1 : qs_e;
                end
                default: begin
                    n_empty = qs_e;
                end
            endcase
        end
        // drop all updates outside the commit cycle
        if (!commit) begin
            head_we = 1'b0;
            tail_we = 1'b0;
            link_we = 1'b0;
            data_we = 1'b0;
        end
    end

    // Control state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld  <= '0;
            r_free_vld  <= 1'b0;
            r_free_cnt  <= '0;
            r_fresh_cnt <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (commit) begin
                r_head_vld  <= n_head_vld;
                r_free_vld  <= n_free_vld;
                r_free_cnt  <= n_free_cnt;
                r_fresh_cnt <= n_fresh_cnt;
                r_out_vld   <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld   <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_free_top <= n_free_top;
            r_status   <= n_status;
            r_data     <= n_data;
            r_empty    <= n_empty;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_status;
    assign o_rsp.data_out  = r_data;
    assign o_rsp.now_empty = r_empty;

endmodule

// ===== hw/rtl/mqll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mqll_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mqll_ctrl.sv =====
// Sequencer that steps each request through pointer reads and the commit cycle.
`timescale 1ns / 1ps
module mqll_ctrl import mqll_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic     i_out_free,
    output t_seq_ctl o_ctl
);

    t_state r_state;
    t_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept) n_state = S_RDQ;
            end
            S_RDQ:  n_state = S_RDT;
            S_RDT:  n_state = S_EXE;
            S_EXE: begin
                // hold until the response register can take the result
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs per state
    always_comb begin
        o_ctl = '0;
        case (r_state)
            S_IDLE:  o_ctl.ready = 1'b1;
            S_RDQ:   o_ctl.rd_q  = 1'b1;
            S_RDT:   o_ctl.rd_t  = 1'b1;
            S_EXE:   o_ctl.exe   = 1'b1;
            default: o_ctl       = '0;
        endcase
    end

endmodule

// ===== hw/rtl/mqll_chk.sv =====
// Port-level checker for the queue manager and its bind to the top level.
`timescale 1ns / 1ps
`include "multi_queue_linked_list_manager_core_assert.svh"
module mqll_chk import mqll_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cmd_valid,
    input logic                    i_cmd_ready,
    input logic                    i_rsp_valid,
    input logic                    i_rsp_ready,
    input logic [STAT_W-1:0]       i_status,
    input logic signed [VAL_W-1:0] i_data_out
);

    // A pending response holds its status until taken
    `MQLL_ASSERT_CLK(a_rsp_hold, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status))

    // One request at a time: ready drops right after an accept
    `MQLL_ASSERT_CLK(a_one_busy, i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)

    // A fresh response follows an accept by the fixed sequence length
    `MQLL_ASSERT_CLK(a_rsp_origin, $rose(i_rsp_valid) |-> $past(i_cmd_valid && i_cmd_ready, 4))

    // Failed requests return no data
    `MQLL_ASSERT_CLK(a_fail_zero, i_rsp_valid && (i_status != STAT_OK) |-> i_data_out == '0)

endmodule

bind multi_queue_linked_list_manager_core mqll_chk u_mqll_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_data_out  (o_rsp.data_out)
);

// ===== bench/queue_manager_checker.sv =====
// Checker for the queue manager: tracks queue state, predicts each response and compares.
`timescale 1ns / 1ps
module queue_manager_checker import mqll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mqll_cmd_if  i_cmd,
    mqll_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] data_out;
        logic                    now_empty;
    } t_queue_result;

    // Shadow copy of the queue heads, tails, node pool and free stack
    logic                    head_vld  [NUM_QUEUES];
    logic [NODE_W-1:0]       head_ix   [NUM_QUEUES];
    logic [NODE_W-1:0]       tail_ix   [NUM_QUEUES];
    logic [NODE_W-1:0]       next_ix   [NODE_COUNT];
    logic signed [VAL_W-1:0] node_val  [NODE_COUNT];
    int                      fresh_used;
    logic                    stack_vld;
    logic [NODE_W-1:0]       stack_top;
    int                      stack_depth;

    t_queue_result pending_results[$];

    // Apply one request to the shadow state and return the response it must produce
    function automatic t_queue_result apply_command(
        input logic [MODE_W-1:0]      mode,
        input logic [SEL_W-1:0]       qs,
        input logic [SEL_W-1:0]       qt,
        input logic signed [VAL_W-1:0] val
    );
        t_queue_result     res;
        logic [NODE_W-1:0] n;
        logic [NODE_W-1:0] h;
        logic              got;
        res.status    = STAT_OK;
        res.data_out  = '0;
        res.now_empty = 1'b1;
        if (int'(qs) < NUM_QUEUES) begin
            case (mode)
                MODE_APPEND: begin
                    // take the free stack's top first, else the next never-used node
                    got = 1'b1;
                    n   = '0;
                    if (stack_vld && stack_depth != 0) begin
                        n           = stack_top;
                        stack_depth = stack_depth - 1;
                        stack_vld   = (stack_depth != 0);
                        stack_top   = (stack_depth != 0) ? next_ix[n] : '0;
                    end else if (fresh_used < NODE_COUNT) begin
                        n          = fresh_used[NODE_W-1:0];
                        fresh_used = fresh_used + 1;
                    end else begin
                        got = 1'b0;
                    end
                    if (got) begin
                        node_val[n] = val;
                        if (!head_vld[qs]) begin
                            head_vld[qs] = 1'b1;
                            head_ix[qs]  = n;
                        end else begin
                            next_ix[tail_ix[qs]] = n;
                        end
                        tail_ix[qs] = n;
                    end else begin
                        res.status = STAT_FULL;
                    end
                    res.now_empty = !head_vld[qs];
                end
                MODE_DEQUEUE: begin
                    if (!head_vld[qs]) begin
                        res.status = STAT_EMPTY;
                    end else begin
                        h            = head_ix[qs];
                        res.data_out = node_val[h];
                        if (h == tail_ix[qs])
                            head_vld[qs] = 1'b0;
                        else
                            head_ix[qs] = next_ix[h];
                        // push the freed node on the free stack
                        next_ix[h]  = stack_vld ? stack_top : '0;
                        stack_top   = h;
                        stack_vld   = 1'b1;
                        stack_depth = stack_depth + 1;
                    end
                    res.now_empty = !head_vld[qs];
                end
                MODE_MERGE: begin
                    // splice the whole source list behind the target's tail
                    if (int'(qt) < NUM_QUEUES && qt != qs && head_vld[qs]) begin
                        if (!head_vld[qt]) begin
                            head_vld[qt] = 1'b1;
                            head_ix[qt]  = head_ix[qs];
                        end else begin
                            next_ix[tail_ix[qt]] = head_ix[qs];
                        end
                        tail_ix[qt]  = tail_ix[qs];
                        head_vld[qs] = 1'b0;
                        tail_ix[qs]  = '0;
                    end
                    if (int'(qt) >= NUM_QUEUES || qt != qs)
                        res.now_empty = 1'b1;
                    else
                        res.now_empty = !head_vld[qs];
                end
                default: begin
                    res.now_empty = !head_vld[qs];
                end
            endcase
        end
        return res;
    endfunction

    // Predict on each accepted request, compare on each accepted response
    always @(posedge i_clk) begin : watch
        t_queue_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++)
                head_vld[i] = 1'b0;
            fresh_used   = 0;
            stack_vld    = 1'b0;
            stack_top    = '0;
            stack_depth  = 0;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                want = apply_command(i_cmd.mode, i_cmd.queue_sel,
                                     i_cmd.other_queue, i_cmd.value);
                pending_results = {pending_results, want};
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $error("response with no request outstanding: status %0d data_out %h",
                           i_rsp.status, i_rsp.data_out);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.data_out !== want.data_out) begin
                        $error("data_out: expected %h, got %h", want.data_out, i_rsp.data_out);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.now_empty !== want.now_empty) begin
                        $error("now_empty: expected %0b, got %0b",
                               want.now_empty, i_rsp.now_empty);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
    import mqll_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pacing_e;
    typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_e;

    logic    i_clk;
    logic    i_rst_n;
    int      fail_count;
    int      pending;
    int      cycle_count;
    int      sent_count;
    pacing_e pacing;

    mqll_cmd_if cmd_ch ();
    mqll_rsp_if rsp_ch ();

    multi_queue_linked_list_manager_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    queue_manager_checker check_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive response back-pressure for the current pacing
    always @(negedge i_clk) begin
        case (pacing)
            PACE_RECEIVER: rsp_ch.ready <= ($urandom_range(99) >= 64);
            PACE_BOTH:     rsp_ch.ready <= ($urandom_range(99) >= 13);
            default:       rsp_ch.ready <= 1'b1;
        endcase
    end

    // Present one request at a falling edge and hold it until accepted
    task automatic push_cmd(input logic [MODE_W-1:0] mode, input logic [SEL_W-1:0] qs,
                            input logic [SEL_W-1:0] qt, input logic [VAL_W-1:0] val);
        int idle_pct;
        idle_pct = (pacing == PACE_SENDER) ? 64 : (pacing == PACE_BOTH) ? 13 : 0;
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= mode;
        cmd_ch.queue_sel   <= qs;
        cmd_ch.other_queue <= qt;
        cmd_ch.value       <= val;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        sent_count = sent_count + 1;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding response has come back
    task automatic hold_until_drained();
        cmd_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    function automatic logic [SEL_W-1:0] pick_queue();
        // favor a few busy queues so dequeues and merges find data
        return ($urandom_range(3) != 0) ? SEL_W'($urandom_range(7)) : SEL_W'($urandom_range(127));
    endfunction

    // Issue random requests with the operation mix of one traffic shape
    task automatic run_random(input mix_e mix, input int count);
        int                roll;
        logic [MODE_W-1:0] op;
        logic [SEL_W-1:0]  src;
        logic [SEL_W-1:0]  dst;
        logic [VAL_W-1:0]  word;
        for (int k = 0; k < count; k++) begin
            pacing = pacing_e'((sent_count / 150) % 4);
            roll   = $urandom_range(99);
            case (mix)
                MIX_FILL:
                    op = (roll < 94) ? MODE_APPEND : (roll < 97) ? MODE_MERGE :
                         (roll < 99) ? MODE_DEQUEUE : MODE_UNUSED;
                MIX_DRAIN:
                    op = (roll < 20) ? MODE_APPEND : (roll < 80) ? MODE_DEQUEUE :
                         (roll < 97) ? MODE_MERGE : MODE_UNUSED;
                default:
                    op = (roll < 40) ? MODE_APPEND : (roll < 75) ? MODE_DEQUEUE :
                         (roll < 93) ? MODE_MERGE : MODE_UNUSED;
            endcase
            src = pick_queue();
            dst = ($urandom_range(9) == 0) ? src : pick_queue();
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0:       word = 32'h0000_0000;
                    1:       word = 32'h7fff_ffff;
                    2:       word = 32'h8000_0000;
                    default: word = 32'hffff_ffff;
                endcase
            end else begin
                word = $urandom();
            end
            push_cmd(op, src, dst, word);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cycle_count        = 0;
        sent_count         = 0;
        pacing             = PACE_NONE;
        cmd_ch.valid       = 1'b0;
        cmd_ch.mode        = MODE_APPEND;
        cmd_ch.queue_sel   = '0;
        cmd_ch.other_queue = '0;
        cmd_ch.value       = '0;
        rsp_ch.ready       = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty dequeue, extreme values, every merge case, unused mode
        push_cmd(MODE_DEQUEUE, 7'd0,   7'd0,   32'h0000_0000);
        push_cmd(MODE_APPEND,  7'd0,   7'd127, 32'h7fff_ffff);
        push_cmd(MODE_APPEND,  7'd0,   7'd0,   32'h8000_0000);
        push_cmd(MODE_APPEND,  7'd127, 7'd0,   32'hffff_ffff);
        push_cmd(MODE_APPEND,  7'd127, 7'd0,   32'h0000_0000);
        push_cmd(MODE_MERGE,   7'd0,   7'd127, 32'h0000_0000);
        push_cmd(MODE_MERGE,   7'd0,   7'd5,   32'h0000_0000);
        push_cmd(MODE_MERGE,   7'd127, 7'd127, 32'h0000_0000);
        push_cmd(MODE_MERGE,   7'd127, 7'd3,   32'h0000_0000);
        push_cmd(MODE_UNUSED,  7'd3,   7'd127, 32'hffff_ffff);
        push_cmd(MODE_UNUSED,  7'd0,   7'd0,   32'h0000_0000);
        push_cmd(MODE_DEQUEUE, 7'd3,   7'd0,   32'h0000_0000);
        push_cmd(MODE_DEQUEUE, 7'd3,   7'd0,   32'h0000_0000);
        push_cmd(MODE_DEQUEUE, 7'd3,   7'd0,   32'h0000_0000);
        push_cmd(MODE_DEQUEUE, 7'd3,   7'd0,   32'h0000_0000);
        push_cmd(MODE_DEQUEUE, 7'd3,   7'd0,   32'h0000_0000);
        push_cmd(MODE_APPEND,  7'd1,   7'd0,   32'h5555_5555);
        push_cmd(MODE_APPEND,  7'd1,   7'd0,   32'haaaa_aaaa);
        push_cmd(MODE_DEQUEUE, 7'd1,   7'd0,   32'h0000_0000);
        push_cmd(MODE_DEQUEUE, 7'd1,   7'd0,   32'h0000_0000);
        hold_until_drained();

        // Random: mixed traffic, then fill past pool capacity, then drain
        run_random(MIX_BALANCED, 300);
        hold_until_drained();
        run_random(MIX_FILL, 1200);
        hold_until_drained();
        run_random(MIX_DRAIN, 300);
        hold_until_drained();

        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
